// ===== rtl/cmb_pkg.sv =====
// ----------------------------------------------------------------------------
// cmb_pkg
// Shared types and constants of the k-combination enumerator: field widths,
// register indexes, register reset values and the configuration and beat structures.
// ----------------------------------------------------------------------------
package cmb_pkg;

   // result and register field widths
   localparam int ELEM_W  = 6;
   localparam int POS_W   = 4;
   localparam int LIMIT_W = 6;
   localparam int COUNT_W = 5;
   localparam int CSR_W   = 6;
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_LIMIT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHOOSE_COUNT = 1'b1;

   // register reset values
   localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST  = 6'd4;
   localparam logic [COUNT_W-1:0] CHOOSE_COUNT_RST = 5'd2;

   // live configuration handed to the sequencer
   typedef struct packed {
      logic [LIMIT_W-1:0] value_limit;
      logic [COUNT_W-1:0] choose_count;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic              strobe;
      logic [ELEM_W-1:0] element_value;
      logic [POS_W-1:0]  element_position;
      logic              last_of_combination;
      logic              none_left;
   } rsp_type;

endpackage

// ===== rtl/combination_enumerator.sv =====
// Order: a restart goes straight to the walk, an advance first scans the
//   store for the pivot; the k beats then come in consecutive cycles.
// Throughput: no new request is taken while busy (scanning or emitting);
//   the combination store has a single read port; a none answer known at
//   acceptance keeps the block idle, one found by a scan that runs out ends it.
// Reset: n=4, k=2, enumeration not started; the store needs no clearing.
// ----------------------------------------------------------------------------
// combination_enumerator
// Lexicographic k-of-n combination enumerator with a plain register port.
// ----------------------------------------------------------------------------
module combination_enumerator
   import cmb_pkg::*;
#(
   parameter int MAX_CHOOSE = 16,
   parameter int VALUE_BITS = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_restart,
   output logic               rsp_strobe,
   output logic [ELEM_W-1:0]  rsp_element_value,
   output logic [POS_W-1:0]   rsp_element_position,
   output logic               rsp_last_of_combination,
   output logic               rsp_none_left,
   input  logic               csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_write_data
);

   localparam int IDX_W = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;

   cfg_type               cfg_ff;
   rsp_type               rsp;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [VALUE_BITS-1:0] mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [VALUE_BITS-1:0] mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.value_limit  <= VALUE_LIMIT_RST;
         cfg_ff.choose_count <= CHOOSE_COUNT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_VALUE_LIMIT:  cfg_ff.value_limit  <= csr_write_data[LIMIT_W-1:0];
            CSR_CHOOSE_COUNT: cfg_ff.choose_count <= csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cmb_seq #(
      .MAX_CHOOSE (MAX_CHOOSE),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_restart (req_restart),
      .busy        (busy),
      .cfg         (cfg_ff),
      .cfg_wr      (csr_write_en),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp         (rsp)
   );

   cmb_store #(
      .DEPTH  (MAX_CHOOSE),
      .DATA_W (VALUE_BITS),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   // result ports
   assign rsp_strobe              = rsp.strobe;
   assign rsp_element_value       = rsp.element_value;
   assign rsp_element_position    = rsp.element_position;
   assign rsp_last_of_combination = rsp.last_of_combination;
   assign rsp_none_left           = rsp.none_left;

endmodule

// ===== rtl/cmb_store.sv =====
// ----------------------------------------------------------------------------
// cmb_store
// Storage of the current combination: one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module cmb_store #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 6,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write the entry, read the addressed entry every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== rtl/cmb_seq.sv =====
// ----------------------------------------------------------------------------
// cmb_seq
// Request sequencer: scans the stored combination from the right for the
// pivot (a restart skips the scan and refills all), then walks the positions,
// emitting the kept prefix from storage and writing back the refilled suffix.
// ----------------------------------------------------------------------------
module cmb_seq
   import cmb_pkg::*;
#(
   parameter int MAX_CHOOSE = 16,
   parameter int VALUE_BITS = 6,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_restart,
   output logic                  busy,
   input  cfg_type               cfg,
   input  logic                  cfg_wr,
   output logic                  mem_wr_en,
   output logic [IDX_W-1:0]      mem_wr_addr,
   output logic [VALUE_BITS-1:0] mem_wr_data,
   output logic [IDX_W-1:0]      mem_rd_addr,
   input  logic [VALUE_BITS-1:0] mem_rd_data,
   output rsp_type               rsp
);

   localparam int K_W   = 7;
   localparam int LIM_W = 8;
   localparam int CMP_W = (VALUE_BITS > LIM_W) ? VALUE_BITS : LIM_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  started_ff, started_in;
   logic                  exhausted_ff, exhausted_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]      issue_ff, issue_in;
   logic [IDX_W-1:0]      pivot_ff, pivot_in;
   logic [VALUE_BITS-1:0] run_val_ff, run_val_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  out_from_mem_ff, out_from_mem_in;
   logic [VALUE_BITS-1:0] out_val_ff, out_val_in;
   logic [IDX_W-1:0]      out_pos_ff, out_pos_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_none_ff, out_none_in;

   logic                  k_valid;
   logic [COUNT_W-1:0]    k_minus_one;
   logic [IDX_W-1:0]      k_last_idx;
   logic                  is_last;
   logic [LIM_W-1:0]      scan_limit;
   logic                  below_limit;
   logic [VALUE_BITS-1:0] out_value;

   // decode the configuration
   always_comb begin
      k_valid     = (cfg.choose_count != '0) &&
                    (K_W'(cfg.choose_count) <= K_W'(MAX_CHOOSE)) &&
                    (LIMIT_W'(cfg.choose_count) <= cfg.value_limit);
      k_minus_one = cfg.choose_count - COUNT_W'(1);
      k_last_idx  = IDX_W'(k_minus_one);
      is_last     = (K_W'(issue_ff) + K_W'(1)) == K_W'(cfg.choose_count);
      // largest value allowed at the scanned position: n - k + i + 1
      scan_limit  = LIM_W'(cfg.value_limit) - LIM_W'(cfg.choose_count) +
                    LIM_W'(scan_idx_ff) + LIM_W'(1);
      below_limit = CMP_W'(mem_rd_data) < CMP_W'(scan_limit);
   end

   assign busy = (state_ff != S_IDLE);

   // next state and beat generation
   always_comb begin
      state_in        = state_ff;
      started_in      = started_ff;
      exhausted_in    = exhausted_ff;
      scan_idx_in     = scan_idx_ff;
      issue_in        = issue_ff;
      pivot_in        = pivot_ff;
      run_val_in      = run_val_ff;
      out_vld_in      = 1'b0;
      out_from_mem_in = out_from_mem_ff;
      out_val_in      = out_val_ff;
      out_pos_in      = out_pos_ff;
      out_last_in     = out_last_ff;
      out_none_in     = out_none_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = issue_ff;
      mem_wr_data     = run_val_ff;
      mem_rd_addr     = issue_ff;

      unique case (state_ff)
         S_IDLE: begin
            mem_rd_addr = k_last_idx;
            if (start) begin
               if (req_restart || !started_ff) begin
                  started_in = 1'b1;
                  if (!k_valid) begin
                     exhausted_in    = 1'b1;
                     out_vld_in      = 1'b1;
                     out_from_mem_in = 1'b0;
                     out_val_in      = '0;
                     out_pos_in      = '0;
                     out_last_in     = 1'b1;
                     out_none_in     = 1'b1;
                  end else begin
                     // fresh start: refill everything from value 1
                     exhausted_in = 1'b0;
                     pivot_in     = '0;
                     run_val_in   = VALUE_BITS'(1);
                     issue_in     = '0;
                     state_in     = S_EMIT;
                  end
               end else if (exhausted_ff || !k_valid) begin
                  out_vld_in      = 1'b1;
                  out_from_mem_in = 1'b0;
                  out_val_in      = '0;
                  out_pos_in      = '0;
                  out_last_in     = 1'b1;
                  out_none_in     = 1'b1;
               end else begin
                  scan_idx_in = k_last_idx;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // data of scan_idx_ff arrives now; prefetch the next one down
            mem_rd_addr = scan_idx_ff - IDX_W'(1);
            if (below_limit) begin
               pivot_in   = scan_idx_ff;
               run_val_in = mem_rd_data + VALUE_BITS'(1);
               issue_in   = '0;
               state_in   = S_EMIT;
            end else if (scan_idx_ff == '0) begin
               exhausted_in    = 1'b1;
               out_vld_in      = 1'b1;
               out_from_mem_in = 1'b0;
               out_val_in      = '0;
               out_pos_in      = '0;
               out_last_in     = 1'b1;
               out_none_in     = 1'b1;
               state_in        = S_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff - IDX_W'(1);
            end
         end
         S_EMIT: begin
            mem_rd_addr = issue_ff;
            out_vld_in  = 1'b1;
            out_pos_in  = issue_ff;
            out_last_in = is_last;
            out_none_in = 1'b0;
            out_val_in  = run_val_ff;
            if (issue_ff >= pivot_ff) begin
               // refill suffix: write back consecutive values
               out_from_mem_in = 1'b0;
               mem_wr_en       = 1'b1;
               run_val_in      = run_val_ff + VALUE_BITS'(1);
            end else begin
               out_from_mem_in = 1'b1;
            end
            if (is_last) begin
               state_in = S_IDLE;
            end else begin
               issue_in = issue_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write drops the enumeration
      if (cfg_wr) begin
         started_in   = 1'b0;
         exhausted_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         exhausted_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         exhausted_ff <= exhausted_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff     <= scan_idx_in;
      issue_ff        <= issue_in;
      pivot_ff        <= pivot_in;
      run_val_ff      <= run_val_in;
      out_from_mem_ff <= out_from_mem_in;
      out_val_ff      <= out_val_in;
      out_pos_ff      <= out_pos_in;
      out_last_ff     <= out_last_in;
      out_none_ff     <= out_none_in;
   end

   // drive the result beat
   assign out_value = out_from_mem_ff ? mem_rd_data : out_val_ff;

   always_comb begin
      rsp.strobe              = out_vld_ff;
      rsp.element_value       = ELEM_W'(out_value);
      rsp.element_position    = POS_W'(out_pos_ff);
      rsp.last_of_combination = out_last_ff;
      rsp.none_left           = out_none_ff;
   end

   // every accepted request is working or answering in the next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (out_vld_ff || state_ff == S_SCAN || state_ff == S_EMIT))
      else $error("accepted request left no trace");

   // beats of one combination come without gaps
   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_last_ff) |=> out_vld_ff)
      else $error("gap inside a combination");

   // the walk keeps going until the last position
   a_emit_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !is_last) |=> (state_ff == S_EMIT && out_vld_ff))
      else $error("emit walk stopped early");

   // running out is always reported by a none beat
   a_exhaust_reported: assert property (@(posedge clock) disable iff (reset)
      $rose(exhausted_ff) |-> (out_vld_ff && out_none_ff && out_last_ff))
      else $error("exhaustion without none beat");

endmodule
